// ===== src/dwms_pkg.sv =====
`timescale 1ns / 1ps

package dwms_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int BEST_W          = 22;
    localparam int LEN_W           = 7;

    // Per-cycle commands broadcast along the row of window cells.
    typedef struct packed {
        logic capture;
        logic shift;
        logic flush;
    } t_cell_ctrl;

endpackage

// ===== src/dwms_cell.sv =====
`timescale 1ns / 1ps

module dwms_cell #(
    parameter int IDX         = 0,
    parameter int VALUE_WIDTH = 16,
    parameter int SUM_W       = 22,
    parameter int CNT_W       = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dwms_pkg::t_cell_ctrl   i_ctrl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [VALUE_WIDTH-1:0] i_cmp_value,
    input  logic [VALUE_WIDTH-1:0] i_prev_value,
    input  logic [SUM_W-1:0]       i_prev_cum,
    output logic [VALUE_WIDTH-1:0] o_value,
    output logic [SUM_W-1:0]       o_cum,
    output logic                   o_match,
    output logic                   o_last
);
    import dwms_pkg::*;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [SUM_W-1:0]       r_cum;
    logic                   r_match;
    logic                   w_occupied;

    assign w_occupied = CNT_W'(IDX) < i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctrl.capture) begin
            r_match <= w_occupied && (r_value == i_cmp_value) && !i_ctrl.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_value <= i_prev_value;
            r_cum   <= i_prev_cum;
        end
    end

    assign o_value = r_value;
    assign o_cum   = r_cum;
    assign o_match = r_match;
    assign o_last  = (i_count == CNT_W'(IDX + 1));

endmodule

// ===== src/distinct_window_max_sum_unit.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_sample_value, i_first_item
// result    out        o_out_valid / i_out_ready   o_best_sum, o_window_hit
// config    in         i_cfg_we                    i_cfg_wdata
//
// Each word is handled in an acceptance cycle, in which every cell compares
// its stored value with the new one, and then an update cycle that shifts the cell row.
// The update cycle waits while a previous result still sits unread in the output register.
// Reset is synchronous and active low; it empties the window and sets the length to one.

module distinct_window_max_sum_unit #(
    parameter int WINDOW_MAX  = dwms_pkg::WINDOW_MAX_DEF,
    parameter int VALUE_WIDTH = dwms_pkg::VALUE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [dwms_pkg::LEN_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [VALUE_WIDTH-1:0]      i_sample_value,
    input  logic                        i_first_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dwms_pkg::BEST_W-1:0] o_best_sum,
    output logic                        o_window_hit
);
    import dwms_pkg::*;

    localparam int SUM_W = VALUE_WIDTH + $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW_MAX);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                   r_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic                   r_first;
    logic [CNT_W-1:0]       r_count;
    logic [CNT_W-1:0]       r_k;
    logic [SUM_W-1:0]       r_total;
    logic [SUM_W-1:0]       r_cum;
    logic [SUM_W-1:0]       r_best;
    logic                   r_hit;
    logic                   r_out_valid;

    logic [CNT_W-1:0]       n_count;
    logic [SUM_W-1:0]       n_total;
    logic [SUM_W-1:0]       n_best;
    logic                   n_hit;

    logic                   w_in_acc;
    logic                   w_adv;
    t_cell_ctrl             w_ctrl;
    logic [CNT_W-1:0]       w_k_cfg;

    logic [VALUE_WIDTH-1:0] w_val [WINDOW_MAX];
    logic [SUM_W-1:0]       w_ccum [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]  w_match;
    logic [WINDOW_MAX-1:0]  w_last;

    logic [CNT_W-1:0]       w_count_eff;
    logic [SUM_W-1:0]       w_total_eff;
    logic [SUM_W-1:0]       w_best_eff;
    logic [SUM_W-1:0]       w_cum_next;
    logic [SUM_W-1:0]       w_sum_add;
    logic [SUM_W-1:0]       w_c_match;
    logic [VALUE_WIDTH-1:0] w_last_val;
    logic [VALUE_WIDTH-1:0] w_oldest;
    logic [IDX_W-1:0]       w_pos;
    logic                   w_any;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_adv      = (r_state == ST_UPD) && (!r_out_valid || i_out_ready);

    assign w_ctrl.capture = w_in_acc;
    assign w_ctrl.shift   = w_adv;
    assign w_ctrl.flush   = i_first_item;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_k_cfg = CNT_W'(1);
        end else if (32'(i_cfg_wdata) > 32'(WINDOW_MAX)) begin
            w_k_cfg = CNT_W'(WINDOW_MAX);
        end else begin
            w_k_cfg = CNT_W'(i_cfg_wdata);
        end
    end

    assign w_cum_next = r_cum + SUM_W'(r_value);

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_prev_value;
            logic [SUM_W-1:0]       w_prev_cum;
            if (g == 0) begin : g_head
                assign w_prev_value = r_value;
                assign w_prev_cum   = w_cum_next;
            end else begin : g_body
                assign w_prev_value = w_val[g-1];
                assign w_prev_cum   = w_ccum[g-1];
            end
            dwms_cell #(
                .IDX        (g),
                .VALUE_WIDTH(VALUE_WIDTH),
                .SUM_W      (SUM_W),
                .CNT_W      (CNT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_count     (r_count),
                .i_cmp_value (i_sample_value),
                .i_prev_value(w_prev_value),
                .i_prev_cum  (w_prev_cum),
                .o_value     (w_val[g]),
                .o_cum       (w_ccum[g]),
                .o_match     (w_match[g]),
                .o_last      (w_last[g])
            );
        end
    endgenerate

    always_comb begin
        w_c_match  = '0;
        w_last_val = '0;
        w_pos      = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (w_match[i]) begin
                w_c_match = w_c_match | w_ccum[i];
                w_pos     = w_pos | IDX_W'(i);
            end
            if (w_last[i]) begin
                w_last_val = w_last_val | w_val[i];
            end
        end
    end

    assign w_any       = |w_match;
    assign w_count_eff = r_first ? '0 : r_count;
    assign w_total_eff = r_first ? '0 : r_total;
    assign w_best_eff  = r_first ? '0 : r_best;
    assign w_sum_add   = w_total_eff + SUM_W'(r_value);
    assign w_oldest    = (w_count_eff == '0) ? r_value : w_last_val;

    always_comb begin
        n_count = w_count_eff + CNT_W'(1);
        n_total = w_sum_add;
        n_best  = w_best_eff;
        n_hit   = 1'b0;
        if (w_any) begin
            n_count = CNT_W'(w_pos) + CNT_W'(1);
            n_total = w_cum_next - w_c_match;
        end else if ((w_count_eff + CNT_W'(1)) >= r_k) begin
            n_hit   = 1'b1;
            n_count = w_count_eff;
            n_total = w_sum_add - SUM_W'(w_oldest);
            if (w_sum_add > w_best_eff) begin
                n_best = w_sum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_k         <= CNT_W'(1);
            r_total     <= '0;
            r_cum       <= '0;
            r_best      <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (w_adv) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                r_k     <= w_k_cfg;
                r_count <= '0;
                r_total <= '0;
            end else if (w_adv) begin
                r_count <= n_count;
                r_total <= n_total;
                r_cum   <= w_cum_next;
                r_best  <= n_best;
                r_hit   <= n_hit;
            end

            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value <= i_sample_value;
            r_first <= i_first_item;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_sum   = BEST_W'(r_best);
    assign o_window_hit = r_hit;

endmodule

// ===== src/dwms_checker.sv =====
`timescale 1ns / 1ps

module dwms_checker #(
    parameter int VALUE_WIDTH = dwms_pkg::VALUE_WIDTH_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [dwms_pkg::LEN_W-1:0]  i_cfg_wdata,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic [VALUE_WIDTH-1:0]      i_sample_value,
    input logic                        i_first_item,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [dwms_pkg::BEST_W-1:0] o_best_sum,
    input logic                        o_window_hit
);
    import dwms_pkg::*;

    logic w_in_acc;

    assign w_in_acc = i_in_valid && o_in_ready;

    // A result word waiting for the sink stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word withdrawn before it was taken");

    // A result word waiting for the sink keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_best_sum) && $stable(o_window_hit))
        else $error("result payload changed while stalled");

    // The unit works on one word at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input taken again during the update cycle");

    // With the output register empty, a word's result is offered once its update cycle is done.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !o_out_valid |-> ##2 o_out_valid)
        else $error("result missing two cycles after acceptance");

endmodule

bind distinct_window_max_sum_unit dwms_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_dwms_checker (.*);
